// ----- hdl/frc4_pkg.sv -----
// Package for the framed RC4 message decipher: constants, register indexes and state codes.
`default_nettype none

package frc4_pkg;

  // Default width of the message length and byte position.
  localparam int LENGTH_BITS_DEF = 24;

  // Framing constants: header length and RC4 key length in bytes.
  localparam int HDR_LEN = 20;
  localparam int KEY_LEN = 16;

  // Last index of the RC4 state table.
  localparam logic [7:0] SBOX_LAST = 8'hFF;

  // Configuration port geometry and register indexes.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY_LO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_XOR_KEY_HI  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SESS_KEY_LO = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SESS_KEY_HI = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_USE_SESSION = 3'd4;

  // Sequencer states.
  typedef enum logic [4:0] {
    ST_IDLE,
    ST_KINIT,
    ST_KA,
    ST_KB,
    ST_KC,
    ST_KD,
    ST_PA,
    ST_PB,
    ST_PC,
    ST_PD,
    ST_PE,
    ST_PF,
    ST_DIV,
    ST_DEC,
    ST_HDR,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

// ----- hdl/frc4_if.sv -----
// Valid/ready channel interfaces for message bytes in and deciphered bytes out.
`default_nettype none

interface frc4_in_if #(
  parameter int LEN_W = frc4_pkg::LENGTH_BITS_DEF
);
  logic             valid;
  logic             ready;
  logic [7:0]       in_byte;
  logic             first_byte;
  logic [LEN_W-1:0] msg_length;

  modport source (output valid, output in_byte, output first_byte, output msg_length,
                  input ready);
  modport sink   (input valid, input in_byte, input first_byte, input msg_length,
                  output ready);
endinterface

interface frc4_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       passthrough;

  modport source (output valid, output out_byte, output out_last, output passthrough,
                  input ready);
  modport sink   (input valid, input out_byte, input out_last, input passthrough,
                  output ready);
endinterface

`default_nettype wire

// ----- hdl/framed_rc4_message_decrypt_top.sv -----
// Framed RC4 message decipher: sequencer, RC4 state memory and remainder unit.
// Usage. Message bytes arrive one item at a time on in_if; the item that carries byte 0
// has first_byte set and brings the total message length. Results leave on out_if, one
// deciphered (or raw) byte per item, with out_last on the final byte. The keys are to be
// set through the plain write port (cfg_we_i, cfg_idx_i, cfg_data_i) while the block is idle;
// the block itself does not enforce this.
// Steps per input item: header bytes 0 to 14 and skipped bytes are only accepted;
//   byte 15 runs the key schedule (fill pass, then four accesses of the single-port
//   state memory per swap); bytes 16 to 19 run the six states of one keystream step;
//   a deciphered payload byte runs those six states and then the output load;
//   byte 19 of a message over 20 bytes also runs the frame remainder (division steps,
//   then a test), unless the block size wraps below 20; when it wraps or the remainder
//   is below 19, the 20 header bytes are replayed in passthrough;
//   passthrough bytes after the header are accepted and then loaded for output.
// out_if is driven straight from the output register.
// in_if.ready is high only while the sequencer is idle. If the receiver stalls, the
// output register holds its item and the sequencer waits in its output step.
// Reset clears the configuration registers, the framing state and the output valid;
// the RC4 state memory and the header store are left as they are, as every message
// writes them before it reads them.
`default_nettype none

module framed_rc4_message_decrypt_top #(
  parameter int LENGTH_BITS = frc4_pkg::LENGTH_BITS_DEF
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [frc4_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [frc4_pkg::CFG_DATA_W-1:0] cfg_data_i,
  frc4_in_if.sink                              in_if,
  frc4_out_if.source                           out_if
);

  localparam int L      = LENGTH_BITS;
  localparam int CNT_W  = $clog2(L);
  localparam int HIDX_W = $clog2(frc4_pkg::HDR_LEN);

  localparam logic [L-1:0]  P_KEY      = L'(frc4_pkg::KEY_LEN - 1);
  localparam logic [L-1:0]  P_HDR      = L'(frc4_pkg::HDR_LEN);
  localparam logic [L-1:0]  P_HDR_LAST = L'(frc4_pkg::HDR_LEN - 1);
  localparam logic [L:0]    P_HDR_X    = (L+1)'(frc4_pkg::HDR_LEN);
  localparam logic [31:0]   B_HDR      = 32'(frc4_pkg::HDR_LEN);
  localparam logic [31:0]   REM_MIN    = 32'(frc4_pkg::HDR_LEN - 1);
  localparam logic [HIDX_W-1:0] HK_LAST = HIDX_W'(frc4_pkg::HDR_LEN - 1);

  // Configuration registers.
  logic [63:0] xor_lo_q, xor_hi_q, sess_lo_q, sess_hi_q;
  logic        use_sess_q;

  // Sequencer and framing state.
  frc4_pkg::state_e state_q, state_d;
  logic [L-1:0]  pos_q, tot_q;
  logic [31:0]   blk_q, off_q;
  logic          raw_q;
  logic [7:0]    i_q, j_q, n_q, si_q, sj_q, byte_q;
  logic          ks_hdr_q, hdr_last_q;
  logic [HIDX_W-1:0] hk_q;
  logic [7:0]    raw_hdr_q [frc4_pkg::HDR_LEN];

  // Remainder unit.
  logic [L-1:0]     dvd_q;
  logic [31:0]      rem_q;
  logic [CNT_W-1:0] cnt_q;
  logic [32:0]      trial, trial_sub;
  logic             trial_ge;

  // Result staging and output register.
  logic [7:0] res_byte_q, out_byte_q;
  logic       res_last_q, res_pt_q, out_last_q, out_pt_q, out_valid_q;
  logic       out_free;

  // RC4 state memory, single port.
  logic [7:0] sbox_mem [256];
  logic       mem_we;
  logic [7:0] mem_addr, mem_wdata, mem_rdata_q;

  // Input decode.
  logic          in_ready, in_acc, first;
  logic [L-1:0]  p_e, tot_e;
  logic [31:0]   blk_e, off_e, dlen, o1;
  logic          raw_e, live, hdr_zone, key_pos, bs_zone, take, frame_end;
  logic          raw_last, pay_last;
  logic [L:0]    p1, nxt;

  // Shared 8-bit adder and key byte.
  logic [HIDX_W-1:0] hdr_rd_idx;
  logic [7:0]        hdr_rd, key_byte, j_sum;
  logic [63:0]       xw, sw;
  logic [31:0]       nb_shift, nb;
  logic [7:0]        ks_byte;

  assign in_acc = in_if.valid && in_ready;
  assign first  = in_if.first_byte;
  assign in_if.ready = in_ready;

  assign out_if.valid       = out_valid_q;
  assign out_if.out_byte    = out_byte_q;
  assign out_if.out_last    = out_last_q;
  assign out_if.passthrough = out_pt_q;
  assign out_free = !out_valid_q || out_if.ready;

  // A new message restarts the framing state before the byte is looked at.
  always_comb begin
    tot_e = first ? L'(in_if.msg_length) : tot_q;
    p_e   = first ? '0 : pos_q;
    blk_e = first ? '0 : blk_q;
    off_e = first ? '0 : off_q;
    raw_e = first ? 1'b0 : raw_q;

    live     = p_e < tot_e;
    hdr_zone = p_e < P_HDR;
    key_pos  = p_e == P_KEY;
    bs_zone  = (p_e > P_KEY) && hdr_zone;

    dlen      = blk_e - B_HDR;
    take      = (off_e < dlen) && (p_e < (tot_e - P_HDR));
    o1        = off_e + 32'd1;
    frame_end = o1 >= blk_e;
    p1        = {1'b0, p_e} + (L+1)'(1);
    nxt       = (o1 < dlen) ? p1 : p1 + P_HDR_X;
    pay_last  = (nxt + P_HDR_X) >= {1'b0, tot_e};
    raw_last  = p_e == (tot_e - L'(1));
  end

  // Key byte for the schedule and the single read port of the header store.
  always_comb begin
    hdr_rd_idx = (state_q == frc4_pkg::ST_HDR) ? hk_q : HIDX_W'(n_q[3:0]);
    hdr_rd     = raw_hdr_q[hdr_rd_idx];
    xw         = n_q[3] ? xor_hi_q : xor_lo_q;
    sw         = n_q[3] ? sess_hi_q : sess_lo_q;
    key_byte   = hdr_rd ^ xw[{n_q[2:0], 3'b000} +: 8] ^
                 (use_sess_q ? sw[{n_q[2:0], 3'b000} +: 8] : 8'h00);
    j_sum      = j_q + mem_rdata_q + ((state_q == frc4_pkg::ST_KB) ? key_byte : 8'h00);
    ks_byte    = byte_q ^ mem_rdata_q;
    nb_shift   = {blk_q[23:0], ks_byte};
    nb         = hdr_last_q ? nb_shift + B_HDR : nb_shift;
    trial      = {rem_q, dvd_q[L-1]};
    trial_sub  = trial - {1'b0, blk_q};
    trial_ge   = trial >= {1'b0, blk_q};
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      frc4_pkg::ST_IDLE: begin
        if (in_acc && live) begin
          if (key_pos) begin
            state_d = frc4_pkg::ST_KINIT;
          end else if (bs_zone) begin
            state_d = frc4_pkg::ST_PA;
          end else if (!hdr_zone) begin
            if (raw_e) begin
              state_d = frc4_pkg::ST_OUT;
            end else if (take) begin
              state_d = frc4_pkg::ST_PA;
            end
          end
        end
      end
      frc4_pkg::ST_KINIT: if (n_q == frc4_pkg::SBOX_LAST) state_d = frc4_pkg::ST_KA;
      frc4_pkg::ST_KA:    state_d = frc4_pkg::ST_KB;
      frc4_pkg::ST_KB:    state_d = frc4_pkg::ST_KC;
      frc4_pkg::ST_KC:    state_d = frc4_pkg::ST_KD;
      frc4_pkg::ST_KD: begin
        state_d = (n_q == frc4_pkg::SBOX_LAST) ? frc4_pkg::ST_IDLE : frc4_pkg::ST_KA;
      end
      frc4_pkg::ST_PA: state_d = frc4_pkg::ST_PB;
      frc4_pkg::ST_PB: state_d = frc4_pkg::ST_PC;
      frc4_pkg::ST_PC: state_d = frc4_pkg::ST_PD;
      frc4_pkg::ST_PD: state_d = frc4_pkg::ST_PE;
      frc4_pkg::ST_PE: state_d = frc4_pkg::ST_PF;
      frc4_pkg::ST_PF: begin
        if (!ks_hdr_q) begin
          state_d = frc4_pkg::ST_OUT;
        end else if (hdr_last_q && (tot_q > P_HDR)) begin
          state_d = (nb < B_HDR) ? frc4_pkg::ST_HDR : frc4_pkg::ST_DIV;
        end else begin
          state_d = frc4_pkg::ST_IDLE;
        end
      end
      frc4_pkg::ST_DIV: if (cnt_q == '0) state_d = frc4_pkg::ST_DEC;
      frc4_pkg::ST_DEC: begin
        state_d = (rem_q < REM_MIN) ? frc4_pkg::ST_HDR : frc4_pkg::ST_IDLE;
      end
      frc4_pkg::ST_HDR: if (out_free && hk_q == HK_LAST) state_d = frc4_pkg::ST_IDLE;
      frc4_pkg::ST_OUT: if (out_free) state_d = frc4_pkg::ST_IDLE;
      default: state_d = frc4_pkg::ST_IDLE;
    endcase
  end

  // Memory port and handshake outputs.
  always_comb begin
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = n_q;
    mem_wdata = mem_rdata_q;
    unique case (state_q)
      frc4_pkg::ST_IDLE:  in_ready = 1'b1;
      frc4_pkg::ST_KINIT: begin
        mem_we    = 1'b1;
        mem_wdata = n_q;
      end
      frc4_pkg::ST_KA: mem_addr = n_q;
      frc4_pkg::ST_KB: mem_addr = j_sum;
      frc4_pkg::ST_KC: mem_we   = 1'b1;
      frc4_pkg::ST_KD: begin
        mem_we    = 1'b1;
        mem_addr  = j_q;
        mem_wdata = si_q;
      end
      frc4_pkg::ST_PA: mem_addr = i_q + 8'd1;
      frc4_pkg::ST_PB: mem_addr = j_sum;
      frc4_pkg::ST_PC: begin
        mem_we   = 1'b1;
        mem_addr = i_q;
      end
      frc4_pkg::ST_PD: begin
        mem_we    = 1'b1;
        mem_addr  = j_q;
        mem_wdata = si_q;
      end
      frc4_pkg::ST_PE: mem_addr = si_q + sj_q;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      sbox_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata_q <= sbox_mem[mem_addr];
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      xor_lo_q   <= '0;
      xor_hi_q   <= '0;
      sess_lo_q  <= '0;
      sess_hi_q  <= '0;
      use_sess_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        frc4_pkg::CFG_XOR_KEY_LO:  xor_lo_q   <= cfg_data_i;
        frc4_pkg::CFG_XOR_KEY_HI:  xor_hi_q   <= cfg_data_i;
        frc4_pkg::CFG_SESS_KEY_LO: sess_lo_q  <= cfg_data_i;
        frc4_pkg::CFG_SESS_KEY_HI: sess_hi_q  <= cfg_data_i;
        frc4_pkg::CFG_USE_SESSION: use_sess_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= frc4_pkg::ST_IDLE;
      pos_q   <= '0;
      tot_q   <= '0;
      blk_q   <= '0;
      off_q   <= '0;
      raw_q   <= 1'b0;
      i_q     <= '0;
      j_q     <= '0;
      n_q     <= '0;
      hk_q    <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        frc4_pkg::ST_IDLE: begin
          if (in_acc) begin
            if (first) begin
              tot_q <= tot_e;
              blk_q <= '0;
              off_q <= '0;
              raw_q <= 1'b0;
              i_q   <= '0;
              j_q   <= '0;
            end
            if (live) begin
              pos_q <= p1[L-1:0];
              if (key_pos) begin
                n_q <= '0;
                j_q <= '0;
              end
              if (!hdr_zone && !raw_e) begin
                off_q <= frame_end ? '0 : o1;
              end
            end else if (first) begin
              pos_q <= '0;
            end
          end
        end
        frc4_pkg::ST_KINIT: n_q <= n_q + 8'd1;
        frc4_pkg::ST_KB:    j_q <= j_sum;
        frc4_pkg::ST_KD: begin
          n_q <= n_q + 8'd1;
          if (n_q == frc4_pkg::SBOX_LAST) begin
            i_q <= '0;
            j_q <= '0;
          end
        end
        frc4_pkg::ST_PA: i_q <= i_q + 8'd1;
        frc4_pkg::ST_PB: j_q <= j_sum;
        frc4_pkg::ST_PF: begin
          if (ks_hdr_q) begin
            blk_q <= nb;
            if (hdr_last_q && (tot_q > P_HDR)) begin
              if (nb < B_HDR) begin
                raw_q <= 1'b1;
                hk_q  <= '0;
              end else begin
                cnt_q <= CNT_W'(L - 1);
              end
            end
          end
        end
        frc4_pkg::ST_DIV: cnt_q <= cnt_q - CNT_W'(1);
        frc4_pkg::ST_DEC: begin
          if (rem_q < REM_MIN) begin
            raw_q <= 1'b1;
            hk_q  <= '0;
          end
        end
        frc4_pkg::ST_HDR: if (out_free) hk_q <= hk_q + HIDX_W'(1);
        default: ;
      endcase
    end
  end

  // Payload registers: header store, keystream operands, remainder unit, result staging.
  always_ff @(posedge clk_i) begin
    case (state_q)
      frc4_pkg::ST_IDLE: begin
        if (in_acc && live) begin
          if (hdr_zone) begin
            raw_hdr_q[p_e[HIDX_W-1:0]] <= in_if.in_byte;
          end
          if (bs_zone) begin
            byte_q     <= in_if.in_byte;
            ks_hdr_q   <= 1'b1;
            hdr_last_q <= p_e == P_HDR_LAST;
          end else if (!hdr_zone) begin
            if (raw_e) begin
              res_byte_q <= in_if.in_byte;
              res_last_q <= raw_last;
              res_pt_q   <= 1'b1;
            end else begin
              byte_q     <= in_if.in_byte;
              ks_hdr_q   <= 1'b0;
              res_last_q <= pay_last;
            end
          end
        end
      end
      frc4_pkg::ST_KB: si_q <= mem_rdata_q;
      frc4_pkg::ST_PB: si_q <= mem_rdata_q;
      frc4_pkg::ST_PC: sj_q <= mem_rdata_q;
      frc4_pkg::ST_PF: begin
        if (!ks_hdr_q) begin
          res_byte_q <= ks_byte;
          res_pt_q   <= 1'b0;
        end
        // Loaded in every step PF; only the last header byte leads on to the remainder unit.
        dvd_q <= tot_q - L'(frc4_pkg::HDR_LEN + 1);
        rem_q <= '0;
      end
      frc4_pkg::ST_DIV: begin
        rem_q <= trial_ge ? trial_sub[31:0] : trial[31:0];
        dvd_q <= dvd_q << 1;
      end
      default: ;
    endcase
  end

  // Output register: loaded from the staging registers or from the header store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if ((state_q == frc4_pkg::ST_OUT || state_q == frc4_pkg::ST_HDR) && out_free) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == frc4_pkg::ST_OUT && out_free) begin
      out_byte_q <= res_byte_q;
      out_last_q <= res_last_q;
      out_pt_q   <= res_pt_q;
    end else if (state_q == frc4_pkg::ST_HDR && out_free) begin
      out_byte_q <= hdr_rd;
      out_last_q <= 1'b0;
      out_pt_q   <= 1'b1;
    end
  end

`ifndef SYNTH
  // The key schedule leaves both RC4 indexes at zero and returns to idle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == frc4_pkg::ST_KD && n_q == frc4_pkg::SBOX_LAST) |=>
      (i_q == 8'd0 && j_q == 8'd0 && state_q == frc4_pkg::ST_IDLE))
    else $error("key schedule did not finish cleanly");

  // The partial remainder always stays below the block size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == frc4_pkg::ST_DIV) |-> (rem_q < blk_q))
    else $error("remainder out of range");

  // Raw header replay only happens in passthrough and within the header.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == frc4_pkg::ST_HDR) |-> (raw_q && hk_q <= HK_LAST))
    else $error("header replay out of range");

  // A first byte always restarts the byte position.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && first) |=> (pos_q <= L'(1)))
    else $error("byte position not restarted");
`endif

endmodule

`default_nettype wire
